// File: rtl/framebuffer_diff_flush_core_assert.svh
// assertion macros for the frame buffer flush core checker
// expects signals named clock and reset in the module that uses them
`ifndef FRAMEBUFFER_DIFF_FLUSH_CORE_ASSERT_SVH
`define FRAMEBUFFER_DIFF_FLUSH_CORE_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define FDF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame buffer flush check failed");

// condition in this cycle implies consequence in the next cycle
`define FDF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame buffer flush check failed");

`endif

// File: rtl/fdf_pkg.sv
// shared constants, codes and control/status types of the frame buffer flush core
// no dependencies
`default_nettype none

package fdf_pkg;

   // panel geometry (width and buffer size are powers of two)
   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int BUFFER_BYTES   = 1024;

   localparam int HALF_COLS  = DISPLAY_WIDTH / 2;
   localparam int HALF_BYTES = BUFFER_BYTES / 2;
   localparam int IDX_W      = $clog2(BUFFER_BYTES);
   localparam int COL_W      = $clog2(HALF_COLS);
   localparam int PAGE_W     = IDX_W - 1 - COL_W;
   localparam int SUM_W      = 16;

   localparam int KIND_W   = 3;
   localparam int RKIND_W  = 2;
   localparam int COORD_W  = 8;
   localparam int BYTE_W   = 8;
   localparam int STEP_W   = 6;

   // panel command bytes
   localparam logic [BYTE_W-1:0] CMD_PAGE = 8'hB8;
   localparam logic [BYTE_W-1:0] CMD_ADDR = 8'h40;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_SET        = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READ       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR_BACK = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR_BOTH = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLUSH      = 3'd4;

   // result kinds
   localparam logic [RKIND_W-1:0] RK_COMMAND = 2'd0;
   localparam logic [RKIND_W-1:0] RK_DATA    = 2'd1;
   localparam logic [RKIND_W-1:0] RK_PIXEL   = 2'd2;
   localparam logic [RKIND_W-1:0] RK_DONE    = 2'd3;

   // one-hot result steps, emitted lowest bit first
   localparam logic [STEP_W-1:0] STEP_PIXEL = 6'b000001;
   localparam logic [STEP_W-1:0] STEP_PAGE  = 6'b000010;
   localparam logic [STEP_W-1:0] STEP_ADDR0 = 6'b000100;
   localparam logic [STEP_W-1:0] STEP_ADDRC = 6'b001000;
   localparam logic [STEP_W-1:0] STEP_DATA  = 6'b010000;
   localparam logic [STEP_W-1:0] STEP_DONE  = 6'b100000;

   typedef struct packed {
      logic accept;   // latch the request, memories read this edge
      logic exec;     // act on the read data
      logic emit;     // load the next result into the output register
      logic sweep;    // zero one byte per cycle
   } ctrl_cmd_type;

   typedef struct packed {
      logic exec_results;  // the request being executed produces results
      logic exec_sweep;    // the request being executed is a clear
      logic emit_last;     // the pending result is the final one
      logic out_free;      // output register can take a result
      logic sweep_done;    // sweep is at the final byte
   } dpath_sts_type;

endpackage

`default_nettype wire

// File: rtl/fdf_ctrl.sv
// controller state machine of the frame buffer flush core
// depends on fdf_pkg
`default_nettype none

module fdf_ctrl
   import fdf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dpath_sts_type sts,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_SWEEP = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.exec_sweep) begin
               state_in = ST_SWEEP;
            end else if (sts.exec_results) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // reset starts with a sweep that zeroes both stores
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/fdf_dpath.sv
// datapath of the frame buffer flush core: both byte stores, flush state,
// result sequencing and output register; depends on fdf_pkg
`default_nettype none

module fdf_dpath
   import fdf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dpath_sts_type       sts,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [COORD_W-1:0]  req_x_coord,
   input  logic [COORD_W-1:0]  req_y_coord,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [RKIND_W-1:0]  rsp_result_kind,
   output logic                rsp_chip_half,
   output logic [BYTE_W-1:0]   rsp_byte_value,
   output logic                rsp_pixel_bit,
   output logic                rsp_in_range,
   output logic                rsp_last
);

   // byte stores
   logic [BYTE_W-1:0] store_a_mem [BUFFER_BYTES];
   logic [BYTE_W-1:0] store_b_mem [BUFFER_BYTES];
   logic [BYTE_W-1:0] rd_a_ff, rd_b_ff;
   logic [IDX_W-1:0]  rd_addr, wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              wr_a, wr_b;

   // pixel address decode
   logic               x_ok, y_ok, loc_ok, loc_half;
   logic [COORD_W-1:0] cx, cy, loc_col;
   logic [SUM_W-1:0]   loc_sum;

   // latched request
   logic [KIND_W-1:0] kind_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [2:0]        bit_ff;
   logic              ok_ff;

   // flush state
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic             back_is_b_ff, back_is_b_in;
   logic             stale_ff, stale_in;
   logic [IDX_W-1:0] sweep_cnt_ff, sweep_cnt_in;

   // result sequencing
   logic [STEP_W-1:0] pend_ff, pend_in, pend_new, lowest, pend_rest;
   logic [BYTE_W-1:0] byte_ff;
   logic              pix_ff;

   logic [BYTE_W-1:0] back_byte, front_byte;
   logic              differ, col_zero, final_byte, clear_both;
   logic              f_half;
   logic [COL_W-1:0]  f_col;
   logic [PAGE_W-1:0] f_page;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RKIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic               rsp_half_ff, rsp_half_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_bit_ff, rsp_bit_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic               rsp_last_ff;

   // pixel (x,y), both 1-based, to byte index and bit
   always_comb begin
      x_ok     = (req_x_coord != '0) && ({1'b0, req_x_coord} <= 9'(DISPLAY_WIDTH));
      y_ok     = (req_y_coord != '0) && ({1'b0, req_y_coord} <= 9'(DISPLAY_HEIGHT));
      cx       = req_x_coord - 8'd1;
      cy       = req_y_coord - 8'd1;
      loc_half = ({1'b0, cx} >= 9'(HALF_COLS));
      loc_col  = loc_half ? (cx - 8'(HALF_COLS)) : cx;
      loc_sum  = (loc_half ? SUM_W'(HALF_BYTES) : '0) + SUM_W'(loc_col)
               + SUM_W'(cy[COORD_W-1:3]) * SUM_W'(HALF_COLS);
      loc_ok   = x_ok && y_ok && (loc_sum < SUM_W'(BUFFER_BYTES));
      rd_addr  = (req_kind == KIND_FLUSH) ? cursor_ff : loc_sum[IDX_W-1:0];
   end

   // flush position of the latched byte index
   assign f_half     = idx_ff[IDX_W-1];
   assign f_col      = idx_ff[COL_W-1:0];
   assign f_page     = idx_ff[IDX_W-2:COL_W];
   assign back_byte  = back_is_b_ff ? rd_b_ff : rd_a_ff;
   assign front_byte = back_is_b_ff ? rd_a_ff : rd_b_ff;
   assign differ     = (back_byte != front_byte);
   assign col_zero   = (f_col == '0);
   assign final_byte = (idx_ff == IDX_W'(BUFFER_BYTES - 1));
   assign clear_both = (kind_ff != KIND_CLEAR_BACK);

   // results owed by the request under execution
   always_comb begin
      pend_new = '0;
      case (kind_ff)
         KIND_READ: begin
            pend_new = STEP_PIXEL;
         end
         KIND_FLUSH: begin
            if (col_zero) begin
               pend_new = pend_new | STEP_PAGE | STEP_ADDR0;
            end
            if (differ && stale_ff) begin
               pend_new = pend_new | STEP_ADDRC;
            end
            if (differ) begin
               pend_new = pend_new | STEP_DATA;
            end
            if (final_byte) begin
               pend_new = pend_new | STEP_DONE;
            end
         end
         default: begin
            pend_new = '0;
         end
      endcase
   end

   // store write port: sweep or pixel read-modify-write
   always_comb begin
      wr_a    = 1'b0;
      wr_b    = 1'b0;
      wr_addr = idx_ff;
      wr_data = back_byte | (8'd1 << bit_ff);
      if (cmd.sweep) begin
         wr_addr = sweep_cnt_ff;
         wr_data = '0;
         wr_a    = clear_both || !back_is_b_ff;
         wr_b    = clear_both || back_is_b_ff;
      end else if (cmd.exec && (kind_ff == KIND_SET) && ok_ff) begin
         wr_a = !back_is_b_ff;
         wr_b = back_is_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         store_a_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_a_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         store_b_mem[wr_addr] <= wr_data;
      end
      rd_b_ff <= store_b_mem[rd_addr];
   end

   // flush state update and sweep counter
   always_comb begin
      cursor_in    = cursor_ff;
      back_is_b_in = back_is_b_ff;
      stale_in     = stale_ff;
      if (cmd.exec && (kind_ff == KIND_FLUSH)) begin
         stale_in = !differ;
         if (final_byte) begin
            cursor_in    = '0;
            back_is_b_in = !back_is_b_ff;
            stale_in     = 1'b1;
         end else begin
            cursor_in = idx_ff + 1'b1;
         end
      end
      sweep_cnt_in = sweep_cnt_ff;
      if (cmd.sweep) begin
         sweep_cnt_in = sts.sweep_done ? '0 : sweep_cnt_ff + 1'b1;
      end
      idx_in = (req_kind == KIND_FLUSH) ? cursor_ff : loc_sum[IDX_W-1:0];
   end

   // pick the lowest pending step
   assign lowest    = pend_ff & (~pend_ff + 1'b1);
   assign pend_rest = pend_ff & ~lowest;

   always_comb begin
      pend_in = pend_ff;
      if (cmd.exec) begin
         pend_in = pend_new;
      end else if (cmd.emit) begin
         pend_in = pend_rest;
      end
   end

   always_comb begin
      rsp_kind_in = RK_COMMAND;
      rsp_half_in = 1'b0;
      rsp_byte_in = '0;
      rsp_bit_in  = 1'b0;
      rsp_ok_in   = 1'b0;
      unique case (lowest)
         STEP_PIXEL: begin
            rsp_kind_in = RK_PIXEL;
            rsp_bit_in  = pix_ff;
            rsp_ok_in   = ok_ff;
         end
         STEP_PAGE: begin
            rsp_half_in = f_half;
            rsp_byte_in = CMD_PAGE | BYTE_W'(f_page);
         end
         STEP_ADDR0: begin
            rsp_half_in = f_half;
            rsp_byte_in = CMD_ADDR;
         end
         STEP_ADDRC: begin
            rsp_half_in = f_half;
            rsp_byte_in = CMD_ADDR | BYTE_W'(f_col);
         end
         STEP_DATA: begin
            rsp_kind_in = RK_DATA;
            rsp_half_in = f_half;
            rsp_byte_in = byte_ff;
         end
         STEP_DONE: begin
            rsp_kind_in = RK_DONE;
         end
         default: begin
            rsp_kind_in = RK_COMMAND;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         back_is_b_ff <= 1'b0;
         stale_ff     <= 1'b1;
         sweep_cnt_ff <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= KIND_CLEAR_BOTH;
      end else begin
         cursor_ff    <= cursor_in;
         back_is_b_ff <= back_is_b_in;
         stale_ff     <= stale_in;
         sweep_cnt_ff <= sweep_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.accept) begin
            kind_ff <= req_kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         idx_ff <= idx_in;
         bit_ff <= cy[2:0];
         ok_ff  <= loc_ok;
      end
      if (cmd.exec) begin
         byte_ff <= back_byte;
         pix_ff  <= ok_ff & back_byte[bit_ff];
      end
      if (cmd.emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_half_ff <= rsp_half_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_bit_ff  <= rsp_bit_in;
         rsp_ok_ff   <= rsp_ok_in;
         rsp_last_ff <= (pend_rest == '0);
      end
   end

   always_comb begin
      sts.exec_results = (pend_new != '0);
      sts.exec_sweep   = (kind_ff == KIND_CLEAR_BACK) || (kind_ff == KIND_CLEAR_BOTH);
      sts.emit_last    = (pend_rest == '0);
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
      sts.sweep_done   = (sweep_cnt_ff == IDX_W'(BUFFER_BYTES - 1));
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_chip_half   = rsp_half_ff;
   assign rsp_byte_value  = rsp_byte_ff;
   assign rsp_pixel_bit   = rsp_bit_ff;
   assign rsp_in_range    = rsp_ok_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/framebuffer_diff_flush_core.sv
// top level of the double-buffered frame buffer with differential flush
// depends on fdf_pkg, fdf_ctrl and fdf_dpath
`default_nettype none

// Double-buffered store for a two-controller monochrome panel, page
// organised, with a back and a front byte store of BUFFER_BYTES each.
// Requests: set pixel ORs one bit into the back store, read pixel answers one
// bit, clear back / clear both zero the stores, and each flush step walks one
// byte, emits page/address commands at the start of a page row and data (with a
// re-address after unchanged bytes) only where back differs from front; the last
// step swaps the roles and emits a frame done mark. The last result of a request
// carries rsp_last. One request is handled at a time. From acceptance until the
// next request can be taken: set pixel does one store read and one
// read-modify-write, ignored kinds a store read and an execute step; read pixel
// and flush step (0 to 4 results) read, execute and then emit each result, and
// wait whenever the output register is stalled; the clears read, execute and
// sweep, zeroing one byte per cycle through the store write ports. After reset
// a clearing pass zeroes both stores; req_stall stays high during it.
// Results pass through an output register, so the next request is accepted
// while the final result of the previous one still waits.

module framebuffer_diff_flush_core
   import fdf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [COORD_W-1:0]  req_x_coord,
   input  logic [COORD_W-1:0]  req_y_coord,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [RKIND_W-1:0]  rsp_result_kind,
   output logic                rsp_chip_half,
   output logic [BYTE_W-1:0]   rsp_byte_value,
   output logic                rsp_pixel_bit,
   output logic                rsp_in_range,
   output logic                rsp_last
);

   ctrl_cmd_type  cmd;
   dpath_sts_type sts;

   // sequencer: clearing sweep, accept, execute, drain pending results
   fdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stores, flush cursor and output register
   fdf_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_kind),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_chip_half   (rsp_chip_half),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_pixel_bit   (rsp_pixel_bit),
      .rsp_in_range    (rsp_in_range),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// File: rtl/fdf_checker.sv
// port-level checker for the frame buffer flush core, bound to the top level
// depends on fdf_pkg and framebuffer_diff_flush_core_assert.svh
`default_nettype none

`include "framebuffer_diff_flush_core_assert.svh"

module fdf_checker
   import fdf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [RKIND_W-1:0] rsp_result_kind,
   input logic               rsp_chip_half,
   input logic [BYTE_W-1:0]  rsp_byte_value,
   input logic               rsp_pixel_bit,
   input logic               rsp_in_range,
   input logic               rsp_last
);

   // a stalled result holds
   `FDF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_byte_value) && $stable(rsp_last))

   // one request at a time: the cycle after acceptance is stalled
   `FDF_ASSERT_NEXT(a_one_request, req_valid && !req_stall, req_stall)

   // a pixel answer is the only result of its request
   `FDF_ASSERT_NOW(a_pixel_last, rsp_valid && (rsp_result_kind == RK_PIXEL), rsp_last)

   // frame done closes the flush step and addresses no controller
   `FDF_ASSERT_NOW(a_done_last, rsp_valid && (rsp_result_kind == RK_DONE), rsp_last && !rsp_chip_half && (rsp_byte_value == '0))

   // pixel fields are zero on every other result
   `FDF_ASSERT_NOW(a_pixel_fields, rsp_valid && (rsp_result_kind != RK_PIXEL), !rsp_pixel_bit && !rsp_in_range)

endmodule

bind framebuffer_diff_flush_core fdf_checker u_fdf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_kind (rsp_result_kind),
   .rsp_chip_half   (rsp_chip_half),
   .rsp_byte_value  (rsp_byte_value),
   .rsp_pixel_bit   (rsp_pixel_bit),
   .rsp_in_range    (rsp_in_range),
   .rsp_last        (rsp_last)
);

`default_nettype wire

// File: tb/framebuffer_diff_flush_core_test.sv
// self-checking testbench for framebuffer_diff_flush_core: pixel set/read, clears and
// the differential flush with role swap, checked against an in-bench frame store model
// depends on fdf_pkg and the framebuffer_diff_flush_core rtl
`timescale 1ns / 100ps

module framebuffer_diff_flush_core_test;
   import fdf_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 11;
   localparam int PAGE_ROWS       = 8;
   // a clear or the power-up clearing pass is the longest silent stretch
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int SETTLE_CYCLES   = BUFFER_BYTES + 64;
   localparam int ITEMS_PER_PHASE = 52;
   localparam int NUM_PHASES      = 4;

   // one result as it leaves the block
   typedef struct packed {
      logic [RKIND_W-1:0] kind;
      logic               half;
      logic [BYTE_W-1:0]  value;
      logic               pixel;
      logic               in_range;
      logic               last;
   } panel_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind = KIND_SET;
   logic [COORD_W-1:0]  req_x_coord = '0;
   logic [COORD_W-1:0]  req_y_coord = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [RKIND_W-1:0]  rsp_result_kind;
   logic                rsp_chip_half;
   logic [BYTE_W-1:0]   rsp_byte_value;
   logic                rsp_pixel_bit;
   logic                rsp_in_range;
   logic                rsp_last;

   // frame store model: two planes, role flag, flush cursor and address tracking
   logic [BYTE_W-1:0]   plane_a [BUFFER_BYTES];
   logic [BYTE_W-1:0]   plane_b [BUFFER_BYTES];
   logic                back_is_b = 1'b0;
   int                  flush_pos = 0;
   logic                addr_stale = 1'b1;

   panel_result_type    expected_results [$];
   panel_result_type    rsp_seen;
   panel_result_type    rsp_want;

   // idling knobs, percent of cycles
   int                  send_gap_pct = 0;
   int                  stall_pct = 0;

   int                  errors = 0;
   int                  requests_sent = 0;
   int                  results_checked = 0;
   int                  frames_swapped = 0;
   int                  quiet_cycles = 0;

   framebuffer_diff_flush_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_chip_half   (rsp_chip_half),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_pixel_bit   (rsp_pixel_bit),
      .rsp_in_range    (rsp_in_range),
      .rsp_last        (rsp_last)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // ------------------------------------------------------------------
   // frame store model
   // ------------------------------------------------------------------

   function automatic panel_result_type result_of(input logic [RKIND_W-1:0] kind,
                                                  input logic half,
                                                  input logic [BYTE_W-1:0] value,
                                                  input logic pixel,
                                                  input logic in_range);
      return '{kind, half, value, pixel, in_range, 1'b0};
   endfunction

   // byte index and bit mask of a 1-based pixel, 0 when off the panel
   function automatic logic pixel_locate(input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y,
                                         output int idx,
                                         output logic [BYTE_W-1:0] mask);
      int cx;
      int cy;
      idx = 0;
      mask = '0;
      if (x < 1 || x > DISPLAY_WIDTH || y < 1 || y > DISPLAY_HEIGHT) return 1'b0;
      cx = int'(x) - 1;
      cy = int'(y) - 1;
      idx = (cx / HALF_COLS) * HALF_BYTES + (cx % HALF_COLS) + (cy / PAGE_ROWS) * HALF_COLS;
      mask = BYTE_W'(1 << (cy % PAGE_ROWS));
      return 1'b1;
   endfunction

   // update the model for one accepted request and queue the results it causes
   task automatic predict_request(input logic [KIND_W-1:0] k,
                                  input logic [COORD_W-1:0] x,
                                  input logic [COORD_W-1:0] y);
      panel_result_type  res [5];
      int                n;
      int                idx;
      int                half;
      int                half_pos;
      int                col;
      int                page;
      logic [BYTE_W-1:0] mask;
      logic [BYTE_W-1:0] back_byte;
      logic [BYTE_W-1:0] front_byte;
      logic              hit;
      n = 0;
      hit = pixel_locate(x, y, idx, mask);
      case (k)
         KIND_SET: begin
            // off-panel sets are dropped silently
            if (hit) begin
               if (back_is_b) plane_b[idx] = plane_b[idx] | mask;
               else plane_a[idx] = plane_a[idx] | mask;
            end
         end
         KIND_READ: begin
            back_byte = back_is_b ? plane_b[idx] : plane_a[idx];
            res[0] = result_of(RK_PIXEL, 1'b0, '0, hit && ((back_byte & mask) != 0), hit);
            n = 1;
         end
         KIND_CLEAR_BACK: begin
            for (int i = 0; i < BUFFER_BYTES; i++) begin
               if (back_is_b) plane_b[i] = '0;
               else plane_a[i] = '0;
            end
         end
         KIND_CLEAR_BOTH: begin
            for (int i = 0; i < BUFFER_BYTES; i++) begin
               plane_a[i] = '0;
               plane_b[i] = '0;
            end
         end
         KIND_FLUSH: begin
            half = flush_pos / HALF_BYTES;
            half_pos = flush_pos % HALF_BYTES;
            page = half_pos / HALF_COLS;
            col = half_pos % HALF_COLS;
            back_byte = back_is_b ? plane_b[flush_pos] : plane_a[flush_pos];
            front_byte = back_is_b ? plane_a[flush_pos] : plane_b[flush_pos];
            // start of a page row: select page, then column 0
            if (col == 0) begin
               res[n] = result_of(RK_COMMAND, half[0], CMD_PAGE | BYTE_W'(page), 1'b0, 1'b0);
               n++;
               res[n] = result_of(RK_COMMAND, half[0], CMD_ADDR, 1'b0, 1'b0);
               n++;
            end
            if (back_byte != front_byte) begin
               // re-address only after a run of unchanged bytes
               if (addr_stale) begin
                  res[n] = result_of(RK_COMMAND, half[0], CMD_ADDR | BYTE_W'(col), 1'b0, 1'b0);
                  n++;
               end
               res[n] = result_of(RK_DATA, half[0], back_byte, 1'b0, 1'b0);
               n++;
               addr_stale = 1'b0;
            end else begin
               addr_stale = 1'b1;
            end
            if (flush_pos == BUFFER_BYTES - 1) begin
               back_is_b = !back_is_b;
               flush_pos = 0;
               addr_stale = 1'b1;
               frames_swapped++;
               res[n] = result_of(RK_DONE, 1'b0, '0, 1'b0, 1'b0);
               n++;
            end else begin
               flush_pos++;
            end
         end
         default: begin
            // spare kinds are ignored
         end
      endcase
      if (n > 0) res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
   endtask

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------

   // optional idle cycles, then hold the request until the block takes it
   task automatic send_request(input logic [KIND_W-1:0] k,
                               input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_x_coord <= x;
      req_y_coord <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(k, x, y);
      requests_sent++;
   endtask

   // sender holds off until every queued result has come back
   task automatic drain_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // a pixel in one of the next few bytes the flush will walk, so edits turn into data
   task automatic pick_near_flush(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
      int k;
      int half_pos;
      k = flush_pos + $urandom_range(7);
      if (k >= BUFFER_BYTES) k = BUFFER_BYTES - 1;
      half_pos = k % HALF_BYTES;
      x = COORD_W'((k / HALF_BYTES) * HALF_COLS + half_pos % HALF_COLS + 1);
      y = COORD_W'((half_pos / HALF_COLS) * PAGE_ROWS + $urandom_range(PAGE_ROWS - 1) + 1);
   endtask

   // mostly near the flush cursor, some anywhere on the panel, some raw 8-bit noise
   task automatic pick_coords(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y);
      int r;
      r = $urandom_range(99);
      if (r < 12) begin
         x = COORD_W'($urandom);
         y = COORD_W'($urandom);
      end else if (r < 67) begin
         pick_near_flush(x, y);
      end else begin
         x = COORD_W'($urandom_range(DISPLAY_WIDTH, 1));
         y = COORD_W'($urandom_range(DISPLAY_HEIGHT, 1));
      end
   endtask

   task automatic set_idling(input int phase);
      case (phase)
         0: begin send_gap_pct = 0;  stall_pct = 0;  end
         1: begin send_gap_pct = 47; stall_pct = 0;  end
         2: begin send_gap_pct = 0;  stall_pct = 47; end
         default: begin send_gap_pct = 25; stall_pct = 25; end
      endcase
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // corners, off-panel coordinates, spare kinds, clears and the first flush steps
   task automatic test_directed;
      send_request(KIND_READ, 8'd1, 8'd1);
      send_request(KIND_SET, 8'd1, 8'd1);
      send_request(KIND_READ, 8'd1, 8'd1);
      send_request(KIND_SET, COORD_W'(DISPLAY_WIDTH), COORD_W'(DISPLAY_HEIGHT));
      send_request(KIND_READ, COORD_W'(DISPLAY_WIDTH), COORD_W'(DISPLAY_HEIGHT));
      // last column of the left half next to first column of the right half
      send_request(KIND_SET, COORD_W'(HALF_COLS), 8'd8);
      send_request(KIND_SET, COORD_W'(HALF_COLS + 1), 8'd9);
      send_request(KIND_READ, COORD_W'(HALF_COLS + 1), 8'd9);
      // off-panel: zero, one past the edge, all ones
      send_request(KIND_SET, 8'd0, 8'd1);
      send_request(KIND_SET, COORD_W'(DISPLAY_WIDTH + 1), 8'd1);
      send_request(KIND_SET, 8'd1, COORD_W'(DISPLAY_HEIGHT + 1));
      send_request(KIND_SET, 8'hFF, 8'hFF);
      send_request(KIND_READ, 8'd0, 8'd1);
      send_request(KIND_READ, COORD_W'(DISPLAY_WIDTH + 1), COORD_W'(DISPLAY_HEIGHT));
      send_request(KIND_READ, 8'hFF, 8'hFF);
      send_request(KIND_W'(KIND_FLUSH + 1), 8'd1, 8'd1);
      send_request({KIND_W{1'b1}}, 8'hFF, 8'h00);
      // byte 0 changed, byte 1 unchanged, byte 2 changed: page select and re-address
      send_request(KIND_SET, 8'd3, 8'd1);
      send_request(KIND_FLUSH, 8'h00, 8'hFF);
      send_request(KIND_FLUSH, 8'hA5, 8'h5A);
      send_request(KIND_FLUSH, 8'hFF, 8'h00);
      send_request(KIND_CLEAR_BACK, 8'h00, 8'h00);
      send_request(KIND_READ, 8'd1, 8'd1);
      send_request(KIND_CLEAR_BOTH, 8'hFF, 8'hFF);
      drain_results;
   endtask

   // random mix of edits, reads, clears and flush steps, with one full drain midway
   task automatic test_random(input int count);
      int                 r;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain_results;
         r = $urandom_range(99);
         pick_coords(x, y);
         if (r < 30) send_request(KIND_SET, x, y);
         else if (r < 48) send_request(KIND_READ, x, y);
         else if (r < 50) send_request(KIND_CLEAR_BACK, x, y);
         else if (r < 51) send_request(KIND_CLEAR_BOTH, x, y);
         else if (r < 54) send_request(KIND_FLUSH + KIND_W'($urandom_range(2, 1)), x, y);
         else send_request(KIND_FLUSH, COORD_W'($urandom), COORD_W'($urandom));
      end
   endtask

   // ------------------------------------------------------------------
   // result checker: each accepted result against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen = '{rsp_result_kind, rsp_chip_half, rsp_byte_value,
                      rsp_pixel_bit, rsp_in_range, rsp_last};
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result kind=%0d half=%0d byte=%02h pixel=%0d ok=%0d last=%0d",
                     $time, rsp_seen.kind, rsp_seen.half, rsp_seen.value, rsp_seen.pixel,
                     rsp_seen.in_range, rsp_seen.last);
         end else begin
            rsp_want = expected_results.pop_front();
            results_checked++;
            if (rsp_seen.kind !== rsp_want.kind || rsp_seen.half !== rsp_want.half ||
                rsp_seen.value !== rsp_want.value || rsp_seen.pixel !== rsp_want.pixel ||
                rsp_seen.in_range !== rsp_want.in_range || rsp_seen.last !== rsp_want.last) begin
               errors++;
               $display("%0t: mismatch expected kind=%0d half=%0d byte=%02h pixel=%0d ok=%0d last=%0d",
                        $time, rsp_want.kind, rsp_want.half, rsp_want.value, rsp_want.pixel,
                        rsp_want.in_range, rsp_want.last);
               $display("%0t:          actual   kind=%0d half=%0d byte=%02h pixel=%0d ok=%0d last=%0d",
                        $time, rsp_seen.kind, rsp_seen.half, rsp_seen.value, rsp_seen.pixel,
                        rsp_seen.in_range, rsp_seen.last);
            end
         end
      end
   end

   // watchdog: too long without any handshake on either side ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_results.size());
            $display("framebuffer_diff_flush_core_test: errors");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      // model state matches the block after reset and its clearing pass
      for (int i = 0; i < BUFFER_BYTES; i++) begin
         plane_a[i] = '0;
         plane_b[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed;
      // each idling mix gets its own stretch of random traffic
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         set_idling(phase);
         test_random(ITEMS_PER_PHASE);
         drain_results;
      end

      // a trailing clear may still be sweeping, give it time to show stray results
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d requests under four idle/stall mixes, %0d results checked",
               requests_sent, results_checked);
      $display("summary: %0d frame swaps, %0d mismatches", frames_swapped, errors);
      if (errors == 0) begin
         $display("framebuffer_diff_flush_core_test: clean");
      end else begin
         $display("framebuffer_diff_flush_core_test: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/fdf_pkg.sv
rtl/fdf_ctrl.sv
rtl/fdf_dpath.sv
rtl/framebuffer_diff_flush_core.sv
rtl/fdf_checker.sv
tb/framebuffer_diff_flush_core_test.sv
